// ----- rtl/rj_pkg.sv -----
package rj_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int THR_WIDTH  = 16;
   localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(7);

   localparam int LANES      = 6;
   localparam int C1_WIDTH   = 2 * DATA_WIDTH;
   localparam int C3_WIDTH   = 3 * DATA_WIDTH;
   localparam int NUM_WIDTH  = 3 * DATA_WIDTH + FRAC_BITS;
   localparam int DEN_WIDTH  = C3_WIDTH;
   localparam int CMP_WIDTH  = 4 * DATA_WIDTH + FRAC_BITS;
   localparam int REQ_DW     = ((4 * DATA_WIDTH + 7) / 8) * 8;
   localparam int RSP_DW     = ((LANES * DATA_WIDTH + 7) / 8) * 8;

   // result lanes, lowest first in rsp_tdata
   localparam int LANE_RANGE_X   = 0;
   localparam int LANE_RANGE_Y   = 1;
   localparam int LANE_BEARING_X = 2;
   localparam int LANE_BEARING_Y = 3;
   localparam int LANE_RATE_X    = 4;
   localparam int LANE_RATE_Y    = 5;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] px_mag;
      logic [DATA_WIDTH-1:0] py_mag;
      logic                  px_neg;
      logic                  py_neg;
      logic [C1_WIDTH:0]     d;      // vx*py - vy*px, two's complement
      logic [C1_WIDTH-1:0]   c1;
   } side_type;

   typedef struct packed {
      logic             degen;
      logic [LANES-1:0] neg;
   } tag_type;

   typedef logic [LANES-1:0][NUM_WIDTH-1:0]  num_type;
   typedef logic [LANES-1:0][DEN_WIDTH-1:0]  den_type;
   typedef logic [LANES-1:0][DATA_WIDTH-1:0] quo_type;

endpackage

// ----- rtl/rj_sqrt.sv -----
module rj_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  rj_pkg::side_type             in_side,
   output logic                         out_valid,
   output rj_pkg::side_type             out_side,
   output logic [rj_pkg::DATA_WIDTH-1:0] out_root
);

   localparam int W  = rj_pkg::DATA_WIDTH;
   localparam int CW = rj_pkg::C1_WIDTH;

   logic [W-1:0]         valid_ff;
   logic [CW-1:0]        rem_ff  [0:W-1];
   logic [CW-1:0]        rem_in  [0:W-1];
   logic [W-1:0]         root_ff [0:W-1];
   logic [W-1:0]         root_in [0:W-1];
   rj_pkg::side_type     side_ff [0:W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[W-2:0], in_valid};
      end
   end

   // one root bit per stage, msb first; rem holds c1 - root^2
   for (genvar s = 0; s < W; s++) begin : g_stage
      localparam int Bit = W - 1 - s;
      logic [CW-1:0] prev_rem;
      logic [W-1:0]  prev_root;
      logic [CW:0]   trial;
      logic          take;

      if (s == 0) begin : g_first
         assign prev_rem  = in_side.c1;
         assign prev_root = '0;
      end else begin : g_next
         assign prev_rem  = rem_ff[s-1];
         assign prev_root = root_ff[s-1];
      end

      always_comb begin
         trial = ((CW+1)'(prev_root) << (Bit + 1)) | ((CW+1)'(1) << (2 * Bit));
         take  = (CW+1)'(prev_rem) >= trial;
         rem_in[s]  = take ? prev_rem - trial[CW-1:0] : prev_rem;
         root_in[s] = take ? prev_root | (W'(1) << Bit) : prev_root;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
            if (s == 0) side_ff[s] <= in_side;
            else        side_ff[s] <= side_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   assign out_valid = valid_ff[W-1];
   assign out_side  = side_ff[W-1];
   assign out_root  = root_ff[W-1];

endmodule

// ----- rtl/rj_div.sv -----
module rj_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  rj_pkg::num_type           in_num,
   input  rj_pkg::den_type           in_den,
   input  rj_pkg::tag_type           in_tag,
   output logic                      out_valid,
   output rj_pkg::quo_type           out_quo,
   output logic [rj_pkg::LANES-1:0]  out_ovf,
   output rj_pkg::tag_type           out_tag
);

   localparam int W  = rj_pkg::DATA_WIDTH;
   localparam int L  = rj_pkg::LANES;
   localparam int CW = rj_pkg::CMP_WIDTH;

   logic [W:0]                  valid_ff;
   logic [L-1:0][CW-1:0]        rem_ff [0:W];
   logic [L-1:0][CW-1:0]        rem_in [0:W];
   rj_pkg::den_type             den_ff [0:W];
   rj_pkg::quo_type             quo_ff [0:W];
   rj_pkg::quo_type             quo_in [0:W];
   logic [L-1:0]                ovf_ff [0:W];
   logic [L-1:0]                ovf_in [0:W];
   rj_pkg::tag_type             tag_ff [0:W];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[W-1:0], in_valid};
      end
   end

   // stage 0 flags quotients of more than W bits, then one bit per stage
   for (genvar k = 0; k <= W; k++) begin : g_stage
      if (k == 0) begin : g_pre
         always_comb begin
            for (int l = 0; l < L; l++) begin
               rem_in[0][l] = CW'(in_num[l]);
               ovf_in[0][l] = CW'(in_num[l]) >= (CW'(in_den[l]) << W);
               quo_in[0][l] = '0;
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[0] <= rem_in[0];
               quo_ff[0] <= quo_in[0];
               ovf_ff[0] <= ovf_in[0];
               den_ff[0] <= in_den;
               tag_ff[0] <= in_tag;
            end
         end
      end else begin : g_bit
         localparam int Bit = W - k;
         always_comb begin
            for (int l = 0; l < L; l++) begin
               if (rem_ff[k-1][l] >= (CW'(den_ff[k-1][l]) << Bit)) begin
                  rem_in[k][l] = rem_ff[k-1][l] - (CW'(den_ff[k-1][l]) << Bit);
                  quo_in[k][l] = quo_ff[k-1][l] | (W'(1) << Bit);
               end else begin
                  rem_in[k][l] = rem_ff[k-1][l];
                  quo_in[k][l] = quo_ff[k-1][l];
               end
            end
            ovf_in[k] = ovf_ff[k-1];
         end
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in[k];
               quo_ff[k] <= quo_in[k];
               ovf_ff[k] <= ovf_in[k];
               den_ff[k] <= den_ff[k-1];
               tag_ff[k] <= tag_ff[k-1];
            end
         end
      end
   end

   assign out_valid = valid_ff[W];
   assign out_quo   = quo_ff[W];
   assign out_ovf   = ovf_ff[W];
   assign out_tag   = tag_ff[W];

endmodule

// ----- rtl/radar_jacobian.sv -----
// channel  | ports                                   | content
// ---------+-----------------------------------------+---------------------------------
// req      | req_tvalid req_tready req_tdata         | pos_x pos_y vel_x vel_y
// rsp      | rsp_tvalid rsp_tready rsp_tdata rsp_tuser | six partials, degenerate flag
// csr      | csr_valid csr_ready csr_data            | zero_threshold
//
// One word per cycle in and out while rsp_tready allows; latency is set by the
// one-bit-per-stage square root and divider pipelines.
// Reset clears the stage valid bits and loads the threshold with its reset value.
// The whole pipeline holds while a result waits on rsp_tready; nothing is dropped.
module radar_jacobian (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // pos_x, pos_y, vel_x, vel_y
   input  logic [rj_pkg::REQ_DW-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // drange_dpx, drange_dpy, dbearing_dpx, dbearing_dpy, drate_dpx, drate_dpy
   output logic [rj_pkg::RSP_DW-1:0] rsp_tdata,
   // degenerate
   output logic                      rsp_tuser,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [rj_pkg::THR_WIDTH-1:0] csr_data
);

   localparam int W   = rj_pkg::DATA_WIDTH;
   localparam int F   = rj_pkg::FRAC_BITS;
   localparam int L   = rj_pkg::LANES;
   localparam int C1W = rj_pkg::C1_WIDTH;
   localparam int C3W = rj_pkg::C3_WIDTH;
   localparam int NW  = rj_pkg::NUM_WIDTH;
   localparam logic [W-1:0] POS_MAX = (W'(1) << (W - 1)) - W'(1);
   localparam logic [W-1:0] NEG_MAG = W'(1) << (W - 1);

   logic adv;
   logic [rj_pkg::THR_WIDTH-1:0] thr_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;

   // stage 1: raw inputs
   logic signed [W-1:0] px1_ff, py1_ff, vx1_ff, vy1_ff;
   // stage 2: squares, cross products, magnitudes
   logic signed [C1W-1:0] pxx_in, pyy_in, vxpy_in, vypx_in;
   logic signed [C1W-1:0] pxx2_ff, pyy2_ff, vxpy2_ff, vypx2_ff;
   logic [W-1:0] pxm2_ff, pym2_ff;
   logic pxn2_ff, pyn2_ff;
   // stage 3: c1 and d
   logic [C1W-1:0] c1_in;
   logic signed [C1W:0] d_in;
   logic [C1W-1:0] c13_ff;
   logic signed [C1W:0] d3_ff;
   logic [W-1:0] pxm3_ff, pym3_ff;
   logic pxn3_ff, pyn3_ff;
   rj_pkg::side_type sq_in_side, sq_side;
   logic sq_valid;
   logic [W-1:0] sq_root;
   // stage 4: c3 partials, |d|
   logic [C1W-1:0] c3lo_in, c3hi_in, dm_in;
   logic [C1W-1:0] c3lo4_ff, c3hi4_ff, dm4_ff, c14_ff;
   logic [W-1:0] c24_ff, pxm4_ff, pym4_ff;
   logic pxn4_ff, pyn4_ff, dn4_ff;
   // stage 5: c3, t partials
   logic [C3W-1:0] c3_in;
   logic [C1W-1:0] ydl_in, ydh_in, xdl_in, xdh_in;
   logic [C3W-1:0] c35_ff;
   logic [C1W-1:0] ydl5_ff, ydh5_ff, xdl5_ff, xdh5_ff, c15_ff;
   logic [W-1:0] c25_ff, pxm5_ff, pym5_ff;
   logic pxn5_ff, pyn5_ff, dn5_ff;
   // stage 6: t sums and near-origin test
   logic [C3W-1:0] ty_in, tx_in;
   logic degen_in;
   logic [C3W-1:0] ty6_ff, tx6_ff, c36_ff;
   logic [C1W-1:0] c16_ff;
   logic [W-1:0] c26_ff, pxm6_ff, pym6_ff;
   logic pxn6_ff, pyn6_ff, dn6_ff, degen6_ff;

   rj_pkg::num_type dv_num;
   rj_pkg::den_type dv_den;
   rj_pkg::tag_type dv_tag, dq_tag;
   rj_pkg::quo_type dq_quo;
   logic [L-1:0] dq_ovf;
   logic dq_valid;

   logic [L-1:0][W-1:0] res_in;
   logic [W-1:0] sat_mag;
   logic [rj_pkg::RSP_DW-1:0] rsp_tdata_ff;
   logic rsp_tvalid_ff, rsp_tuser_ff;

   assign adv        = rsp_tready || !rsp_tvalid_ff;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= rj_pkg::THR_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= sq_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         rsp_tvalid_ff <= dq_valid;
      end
   end

   assign pxx_in  = px1_ff * px1_ff;
   assign pyy_in  = py1_ff * py1_ff;
   assign vxpy_in = vx1_ff * py1_ff;
   assign vypx_in = vy1_ff * px1_ff;
   assign c1_in   = $unsigned(pxx2_ff) + $unsigned(pyy2_ff);
   assign d_in    = (C1W+1)'(vxpy2_ff) - (C1W+1)'(vypx2_ff);

   always_comb begin
      sq_in_side.px_mag = pxm3_ff;
      sq_in_side.py_mag = pym3_ff;
      sq_in_side.px_neg = pxn3_ff;
      sq_in_side.py_neg = pyn3_ff;
      sq_in_side.d      = d3_ff;
      sq_in_side.c1     = c13_ff;
   end

   rj_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v3_ff),
      .in_side   (sq_in_side),
      .out_valid (sq_valid),
      .out_side  (sq_side),
      .out_root  (sq_root)
   );

   assign c3lo_in = sq_side.c1[W-1:0] * sq_root;
   assign c3hi_in = sq_side.c1[C1W-1:W] * sq_root;
   assign dm_in   = sq_side.d[C1W] ? C1W'(-sq_side.d) : sq_side.d[C1W-1:0];

   assign c3_in  = C3W'(c3lo4_ff) + (C3W'(c3hi4_ff) << W);
   assign ydl_in = pym4_ff * dm4_ff[W-1:0];
   assign ydh_in = pym4_ff * dm4_ff[C1W-1:W];
   assign xdl_in = pxm4_ff * dm4_ff[W-1:0];
   assign xdh_in = pxm4_ff * dm4_ff[C1W-1:W];

   assign ty_in = C3W'(ydl5_ff) + (C3W'(ydh5_ff) << W);
   assign tx_in = C3W'(xdl5_ff) + (C3W'(xdh5_ff) << W);
   assign degen_in = (c15_ff == '0)
                  || (c15_ff < (C1W'(thr_ff) << F))
                  || (c25_ff < W'(thr_ff))
                  || (c35_ff < (C3W'(thr_ff) << (2 * F)));

   always_ff @(posedge clock) begin
      if (adv) begin
         px1_ff <= req_tdata[W-1:0];
         py1_ff <= req_tdata[2*W-1:W];
         vx1_ff <= req_tdata[3*W-1:2*W];
         vy1_ff <= req_tdata[4*W-1:3*W];

         pxx2_ff  <= pxx_in;
         pyy2_ff  <= pyy_in;
         vxpy2_ff <= vxpy_in;
         vypx2_ff <= vypx_in;
         pxm2_ff  <= px1_ff[W-1] ? W'(-px1_ff) : px1_ff;
         pym2_ff  <= py1_ff[W-1] ? W'(-py1_ff) : py1_ff;
         pxn2_ff  <= px1_ff[W-1];
         pyn2_ff  <= py1_ff[W-1];

         c13_ff  <= c1_in;
         d3_ff   <= d_in;
         pxm3_ff <= pxm2_ff;
         pym3_ff <= pym2_ff;
         pxn3_ff <= pxn2_ff;
         pyn3_ff <= pyn2_ff;

         c3lo4_ff <= c3lo_in;
         c3hi4_ff <= c3hi_in;
         dm4_ff   <= dm_in;
         dn4_ff   <= sq_side.d[C1W];
         c14_ff   <= sq_side.c1;
         c24_ff   <= sq_root;
         pxm4_ff  <= sq_side.px_mag;
         pym4_ff  <= sq_side.py_mag;
         pxn4_ff  <= sq_side.px_neg;
         pyn4_ff  <= sq_side.py_neg;

         c35_ff  <= c3_in;
         ydl5_ff <= ydl_in;
         ydh5_ff <= ydh_in;
         xdl5_ff <= xdl_in;
         xdh5_ff <= xdh_in;
         c15_ff  <= c14_ff;
         c25_ff  <= c24_ff;
         pxm5_ff <= pxm4_ff;
         pym5_ff <= pym4_ff;
         pxn5_ff <= pxn4_ff;
         pyn5_ff <= pyn4_ff;
         dn5_ff  <= dn4_ff;

         ty6_ff    <= ty_in;
         tx6_ff    <= tx_in;
         c36_ff    <= c35_ff;
         c16_ff    <= c15_ff;
         c26_ff    <= c25_ff;
         pxm6_ff   <= pxm5_ff;
         pym6_ff   <= pym5_ff;
         pxn6_ff   <= pxn5_ff;
         pyn6_ff   <= pyn5_ff;
         dn6_ff    <= dn5_ff;
         degen6_ff <= degen_in;
      end
   end

   always_comb begin
      dv_num[rj_pkg::LANE_RANGE_X]   = NW'(pxm6_ff) << F;
      dv_num[rj_pkg::LANE_RANGE_Y]   = NW'(pym6_ff) << F;
      dv_num[rj_pkg::LANE_BEARING_X] = NW'(pym6_ff) << (2 * F);
      dv_num[rj_pkg::LANE_BEARING_Y] = NW'(pxm6_ff) << (2 * F);
      dv_num[rj_pkg::LANE_RATE_X]    = NW'(ty6_ff) << F;
      dv_num[rj_pkg::LANE_RATE_Y]    = NW'(tx6_ff) << F;
      dv_den[rj_pkg::LANE_RANGE_X]   = rj_pkg::DEN_WIDTH'(c26_ff);
      dv_den[rj_pkg::LANE_RANGE_Y]   = rj_pkg::DEN_WIDTH'(c26_ff);
      dv_den[rj_pkg::LANE_BEARING_X] = rj_pkg::DEN_WIDTH'(c16_ff);
      dv_den[rj_pkg::LANE_BEARING_Y] = rj_pkg::DEN_WIDTH'(c16_ff);
      dv_den[rj_pkg::LANE_RATE_X]    = c36_ff;
      dv_den[rj_pkg::LANE_RATE_Y]    = c36_ff;
      dv_tag.degen = degen6_ff;
      dv_tag.neg[rj_pkg::LANE_RANGE_X]   = pxn6_ff;
      dv_tag.neg[rj_pkg::LANE_RANGE_Y]   = pyn6_ff;
      dv_tag.neg[rj_pkg::LANE_BEARING_X] = !pyn6_ff;
      dv_tag.neg[rj_pkg::LANE_BEARING_Y] = pxn6_ff;
      dv_tag.neg[rj_pkg::LANE_RATE_X]    = pyn6_ff ^ dn6_ff;
      dv_tag.neg[rj_pkg::LANE_RATE_Y]    = !(pxn6_ff ^ dn6_ff);
   end

   rj_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v6_ff),
      .in_num    (dv_num),
      .in_den    (dv_den),
      .in_tag    (dv_tag),
      .out_valid (dq_valid),
      .out_quo   (dq_quo),
      .out_ovf   (dq_ovf),
      .out_tag   (dq_tag)
   );

   // saturate, zero for degenerate words; negative side reaches one step further
   always_comb begin
      sat_mag = '0;
      for (int l = 0; l < L; l++) begin
         if (dq_tag.degen) begin
            res_in[l] = '0;
         end else if (!dq_tag.neg[l]) begin
            res_in[l] = (dq_ovf[l] || dq_quo[l] > POS_MAX) ? POS_MAX : dq_quo[l];
         end else begin
            sat_mag   = (dq_ovf[l] || dq_quo[l] > NEG_MAG) ? NEG_MAG : dq_quo[l];
            res_in[l] = W'(-sat_mag);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= rj_pkg::RSP_DW'(res_in);
         rsp_tuser_ff <= dq_tag.degen;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ----- rtl/rj_checker.sv -----
module rj_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [rj_pkg::RSP_DW-1:0]    rsp_tdata,
   input logic                         rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("degenerate word carries nonzero entries");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result word changed");

   a_stall_back: assert property (@(posedge clock)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while output stalled");

   a_idle_ready: assert property (@(posedge clock)
      !rsp_tvalid |-> req_tready)
      else $error("input not ready with empty output");

endmodule

bind radar_jacobian rj_checker u_rj_checker (.*);
